// ----- design/pee_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam int WORD_BITS = 32;
   localparam int ADD_W     = WORD_BITS + 2;
   localparam int STEP_W    = $clog2(WORD_BITS);
   localparam int STATUS_W  = 3;
   localparam int TOKEN_W   = 8;

   // Character codes.
   localparam logic [TOKEN_W-1:0] TOK_PLUS  = 8'h2B;
   localparam logic [TOKEN_W-1:0] TOK_MINUS = 8'h2D;
   localparam logic [TOKEN_W-1:0] TOK_STAR  = 8'h2A;
   localparam logic [TOKEN_W-1:0] TOK_SLASH = 8'h2F;
   localparam logic [TOKEN_W-1:0] TOK_CARET = 8'h5E;
   localparam logic [TOKEN_W-1:0] ZERO_CODE = 8'h30;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DIVZERO     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY       = 3'd5;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_MUL = 2'd2,
      ALU_DIV = 2'd3
   } alu_op_type;

   typedef struct packed {
      logic                 start;
      alu_op_type           op;
      logic [WORD_BITS-1:0] lhs;
      logic [WORD_BITS-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] result;
   } alu_rsp_type;

endpackage

// ----- design/pee_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_channels
// Valid/ready channel interfaces for characters in and results out.
// ----------------------------------------------------------------------------
interface pee_req_if;
   import pee_pkg::*;

   logic               valid;
   logic               ready;
   logic [TOKEN_W-1:0] token;
   logic               last;

   modport source (output valid, output token, output last, input ready);
   modport sink (input valid, input token, input last, output ready);
endinterface

interface pee_rsp_if;
   import pee_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] result_value;
   logic [STATUS_W-1:0]         status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink (input valid, input result_value, input status, output ready);
endinterface

// ----- design/pee_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_alu
// Iterative arithmetic unit built around one shared adder: add and subtract
// in one step, shift-add multiply and restoring divide one bit per step.
// ----------------------------------------------------------------------------
module pee_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  pee_pkg::alu_req_type alu_req,
   output pee_pkg::alu_rsp_type alu_rsp
);
   import pee_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_NEG_L = 5'b00010,
      PH_NEG_R = 5'b00100,
      PH_LOOP  = 5'b01000,
      PH_NEG_Q = 5'b10000
   } phase_type;

   phase_type            phase_ff, phase_in;
   alu_op_type           op_ff, op_in;
   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 neg_ff, neg_in;
   logic                 done_ff, done_in;

   logic [ADD_W-1:0]     add_x;
   logic [ADD_W-1:0]     add_y;
   logic                 add_c;
   logic [ADD_W-1:0]     sum;
   logic                 fits;
   logic                 step_last;

   // Shared adder operand selection.
   always_comb begin
      add_x = '0;
      add_y = '0;
      add_c = 1'b0;
      unique case (phase_ff)
         PH_NEG_L, PH_NEG_Q: begin
            add_y = ~{2'b00, a_ff};
            add_c = 1'b1;
         end
         PH_NEG_R: begin
            add_y = ~{2'b00, b_ff};
            add_c = 1'b1;
         end
         PH_LOOP: begin
            unique case (op_ff)
               ALU_ADD: begin
                  add_x = {2'b00, a_ff};
                  add_y = {2'b00, b_ff};
               end
               ALU_SUB: begin
                  add_x = {2'b00, a_ff};
                  add_y = ~{2'b00, b_ff};
                  add_c = 1'b1;
               end
               ALU_MUL: begin
                  add_x = {2'b00, acc_ff};
                  add_y = b_ff[0] ? {2'b00, a_ff} : '0;
               end
               ALU_DIV: begin
                  // Partial remainder shifted left with the next dividend bit.
                  add_x = {1'b0, acc_ff, a_ff[WORD_BITS-1]};
                  add_y = ~{2'b00, b_ff};
                  add_c = 1'b1;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      sum = add_x + add_y + ADD_W'(add_c);
   end

   assign fits      = ~sum[ADD_W-1];
   assign step_last = (step_ff == STEP_W'(WORD_BITS - 1));

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (alu_req.start) begin
               op_in    = alu_req.op;
               a_in     = alu_req.lhs;
               b_in     = alu_req.rhs;
               acc_in   = '0;
               step_in  = '0;
               neg_in   = alu_req.lhs[WORD_BITS-1] ^ alu_req.rhs[WORD_BITS-1];
               phase_in = (alu_req.op == ALU_DIV) ? PH_NEG_L : PH_LOOP;
            end
         end
         PH_NEG_L: begin
            if (a_ff[WORD_BITS-1]) begin
               a_in = sum[WORD_BITS-1:0];
            end
            phase_in = PH_NEG_R;
         end
         PH_NEG_R: begin
            if (b_ff[WORD_BITS-1]) begin
               b_in = sum[WORD_BITS-1:0];
            end
            phase_in = PH_LOOP;
         end
         PH_LOOP: begin
            unique case (op_ff)
               ALU_ADD, ALU_SUB: begin
                  acc_in   = sum[WORD_BITS-1:0];
                  done_in  = 1'b1;
                  phase_in = PH_IDLE;
               end
               ALU_MUL: begin
                  acc_in  = sum[WORD_BITS-1:0];
                  a_in    = {a_ff[WORD_BITS-2:0], 1'b0};
                  b_in    = {1'b0, b_ff[WORD_BITS-1:1]};
                  step_in = step_ff + STEP_W'(1);
                  if (step_last) begin
                     done_in  = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               ALU_DIV: begin
                  acc_in  = fits ? sum[WORD_BITS-1:0] : add_x[WORD_BITS-1:0];
                  a_in    = {a_ff[WORD_BITS-2:0], fits};
                  step_in = step_ff + STEP_W'(1);
                  if (step_last) begin
                     phase_in = PH_NEG_Q;
                  end
               end
               default: ;
            endcase
         end
         PH_NEG_Q: begin
            acc_in   = neg_ff ? sum[WORD_BITS-1:0] : a_ff;
            done_in  = 1'b1;
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = acc_ff;

endmodule

// ----- design/postfix_expression_evaluator_unit.sv -----
// The final character also passes through a final state, which delivers the result.
// Throughput: one character at a time; the shared adder in the arithmetic
// unit, one bit per cycle for * and /, sets the long cases.
// Reset: synchronous; empties the stack, clears the error and drops any result.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Evaluates a postfix expression streamed one character per transfer and
// returns the top of the operand stack with a status on the final character.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit #(
   parameter int STACK_DEPTH = 32
) (
   input logic     clock,
   input logic     reset,
   pee_req_if.sink   req_ch,
   pee_rsp_if.source rsp_ch
);
   import pee_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_RD_LHS = 7'b0000100,
      S_EXEC   = 7'b0001000,
      S_ALU    = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_FINAL  = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [STATUS_W-1:0]  err_ff, err_in;
   logic [TOKEN_W-1:0]   tok_ff, tok_in;
   logic                 last_ff, last_in;
   logic [WORD_BITS-1:0] rhs_ff, rhs_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [WORD_BITS-1:0] stack_mem [STACK_DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic [CNT_W-1:0]     cnt_m1;
   logic [CNT_W-1:0]     cnt_m2;
   logic                 is_op;
   logic                 stack_full;
   logic                 req_fire;
   alu_op_type           dec_op;
   alu_req_type          alu_req;
   alu_rsp_type          alu_rsp;

   pee_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign cnt_m1     = count_ff - CNT_W'(1);
   assign cnt_m2     = count_ff - CNT_W'(2);
   assign stack_full = (count_ff == CNT_W'(STACK_DEPTH));
   assign is_op      = (tok_ff == TOK_PLUS) || (tok_ff == TOK_MINUS) ||
                       (tok_ff == TOK_STAR) || (tok_ff == TOK_SLASH);
   assign req_fire   = req_ch.valid && req_ch.ready;

   always_comb begin
      priority if (tok_ff == TOK_PLUS) begin
         dec_op = ALU_ADD;
      end else if (tok_ff == TOK_MINUS) begin
         dec_op = ALU_SUB;
      end else if (tok_ff == TOK_STAR) begin
         dec_op = ALU_MUL;
      end else begin
         dec_op = ALU_DIV;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      tok_in        = tok_ff;
      last_in       = last_ff;
      rhs_in        = rhs_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = cnt_m1[ADDR_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[ADDR_W-1:0];
      wr_data       = '0;
      alu_req.start = 1'b0;
      alu_req.op    = dec_op;
      alu_req.lhs   = rd_data_ff;
      alu_req.rhs   = rhs_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               tok_in   = req_ch.token;
               last_in  = req_ch.last;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // Once an error is latched, the rest of the expression is ignored.
            priority if (err_ff != STATUS_OK) begin
               state_in = S_FINISH;
            end else if (is_op) begin
               if (count_ff < CNT_W'(2)) begin
                  err_in   = STATUS_UNDERFLOW;
                  state_in = S_FINISH;
               end else begin
                  state_in = S_RD_LHS;
               end
            end else if (tok_ff == TOK_CARET) begin
               err_in   = STATUS_UNSUPPORTED;
               state_in = S_FINISH;
            end else if (stack_full) begin
               err_in   = STATUS_OVERFLOW;
               state_in = S_FINISH;
            end else begin
               wr_en    = 1'b1;
               wr_data  = WORD_BITS'(tok_ff) - WORD_BITS'(ZERO_CODE);
               count_in = count_ff + CNT_W'(1);
               state_in = S_FINISH;
            end
         end
         S_RD_LHS: begin
            rhs_in   = rd_data_ff;
            rd_addr  = cnt_m2[ADDR_W-1:0];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if ((dec_op == ALU_DIV) && (rhs_ff == '0)) begin
               err_in   = STATUS_DIVZERO;
               state_in = S_FINISH;
            end else begin
               alu_req.start = 1'b1;
               state_in      = S_ALU;
            end
         end
         S_ALU: begin
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               wr_addr  = cnt_m2[ADDR_W-1:0];
               wr_data  = alu_rsp.result;
               count_in = cnt_m1;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = last_ff ? S_FINAL : S_IDLE;
         end
         S_FINAL: begin
            // The top entry was read in the previous cycle and is still held.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               priority if (err_ff != STATUS_OK) begin
                  rsp_value_in  = '0;
                  rsp_status_in = err_ff;
               end else if (count_ff == '0) begin
                  rsp_value_in  = '0;
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_value_in  = rd_data_ff;
                  rsp_status_in = STATUS_OK;
               end
               count_in = '0;
               err_in   = STATUS_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff        <= tok_in;
      last_ff       <= last_in;
      rhs_ff        <= rhs_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign req_ch.ready        = (state_ff == S_IDLE) && !reset;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;

endmodule

// ----- design/pee_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pee_checker
// Port-level checks of the postfix expression evaluator, bound to the top.
// ----------------------------------------------------------------------------
module pee_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [pee_pkg::WORD_BITS-1:0] rsp_result_value,
   input logic [pee_pkg::STATUS_W-1:0]         rsp_status
);
   import pee_pkg::*;

   // A result that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) &&
                                  $stable(rsp_status))
      else $error("result changed while stalled");

   // A character transfer starts work, so the block cannot take another next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on consecutive cycles");

   // Any failed expression reports a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_result_value == '0)
      else $error("nonzero value with error status");

   // A new result appears only once the block has finished and is ready again.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result raised while still busy");

endmodule

bind postfix_expression_evaluator_unit pee_checker u_pee_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_status       (rsp_ch.status)
);

// ----- tb/sv/postfix_expression_evaluator_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit_checker
// Watches the character and result channels and predicts each expression's
// value and status. Every result transfer is compared field by field with the
// oldest prediction. Failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit_checker #(
   parameter int STACK_DEPTH = 32
) (
   input  logic clock,
   input  logic reset,
   pee_req_if   req_mon,
   pee_rsp_if   rsp_mon,
   output int   fail_count,
   output int   results_outstanding
);
   import pee_pkg::*;

   typedef struct {
      logic [WORD_BITS-1:0] value;
      logic [STATUS_W-1:0]  status;
   } eval_result_type;

   logic [WORD_BITS-1:0] operand_mem [STACK_DEPTH];
   int                   live_count;
   logic [STATUS_W-1:0]  first_error;
   eval_result_type      pending_results[$];

   initial begin
      fail_count          = 0;
      results_outstanding = 0;
      live_count          = 0;
      first_error         = STATUS_OK;
   end

   // Applies one character to the predicted stack; on the final character it
   // queues the predicted result and starts a fresh expression.
   task automatic evaluate_char(input logic [TOKEN_W-1:0] tok, input logic fin);
      logic [WORD_BITS-1:0] lhs;
      logic [WORD_BITS-1:0] rhs;
      logic [WORD_BITS-1:0] res;
      logic [WORD_BITS-1:0] lhs_mag;
      logic [WORD_BITS-1:0] rhs_mag;
      eval_result_type      outcome;
      if (first_error == STATUS_OK) begin
         if (tok == TOK_PLUS || tok == TOK_MINUS || tok == TOK_STAR || tok == TOK_SLASH) begin
            if (live_count < 2) begin
               first_error = STATUS_UNDERFLOW;
            end else begin
               rhs = operand_mem[live_count-1];
               lhs = operand_mem[live_count-2];
               if (tok == TOK_SLASH && rhs == '0) begin
                  first_error = STATUS_DIVZERO;
               end else begin
                  case (tok)
                     TOK_PLUS:  res = lhs + rhs;
                     TOK_MINUS: res = lhs - rhs;
                     TOK_STAR:  res = lhs * rhs;
                     default: begin
                        // Divide magnitudes, then apply the sign: truncation
                        // toward zero, and the most negative value over minus
                        // one wraps back onto itself.
                        lhs_mag = lhs[WORD_BITS-1] ? -lhs : lhs;
                        rhs_mag = rhs[WORD_BITS-1] ? -rhs : rhs;
                        res     = lhs_mag / rhs_mag;
                        if (lhs[WORD_BITS-1] != rhs[WORD_BITS-1]) res = -res;
                     end
                  endcase
                  live_count = live_count - 1;
                  operand_mem[live_count-1] = res;
               end
            end
         end else if (tok == TOK_CARET) begin
            first_error = STATUS_UNSUPPORTED;
         end else if (live_count >= STACK_DEPTH) begin
            first_error = STATUS_OVERFLOW;
         end else begin
            operand_mem[live_count] = WORD_BITS'(tok) - WORD_BITS'(ZERO_CODE);
            live_count = live_count + 1;
         end
      end
      if (fin) begin
         outcome.value  = '0;
         outcome.status = first_error;
         if (first_error == STATUS_OK) begin
            if (live_count == 0) outcome.status = STATUS_EMPTY;
            else outcome.value = operand_mem[live_count-1];
         end
         pending_results.push_back(outcome);
         live_count  = 0;
         first_error = STATUS_OK;
      end
   endtask

   always @(posedge clock) begin
      eval_result_type want;
      if (reset) begin
         live_count  = 0;
         first_error = STATUS_OK;
      end else begin
         if (req_mon.valid && req_mon.ready) evaluate_char(req_mon.token, req_mon.last);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with nothing expected: result_value %0d status %0d",
                      rsp_mon.result_value, rsp_mon.status);
               fail_count = fail_count + 1;
            end else begin
               want = pending_results.pop_front();
               if (rsp_mon.result_value !== want.value) begin
                  $error("result_value: expected %0d, got %0d",
                         $signed(want.value), rsp_mon.result_value);
                  fail_count = fail_count + 1;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      results_outstanding = pending_results.size();
   end

endmodule

// ----- tb/sv/postfix_expression_evaluator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit_tb
// Streams directed and random postfix expressions into the evaluator with
// random gaps on the sender and random stalls on the result side. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_unit_tb;
   import pee_pkg::*;

   localparam int DEPTH       = 32;
   localparam int CHAR_TARGET = 550;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 60;

   logic clock;
   logic reset;
   logic steady;
   int   fail_count;
   int   results_outstanding;
   int   chars_sent;
   int   idle_cycles;

   logic [TOKEN_W-1:0] expr_q[$];

   pee_req_if req_ch ();
   pee_rsp_if rsp_ch ();

   postfix_expression_evaluator_unit #(
      .STACK_DEPTH(DEPTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   postfix_expression_evaluator_unit_checker #(
      .STACK_DEPTH(DEPTH)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_ch),
      .rsp_mon            (rsp_ch),
      .fail_count         (fail_count),
      .results_outstanding(results_outstanding)
   );

   always #2 clock = ~clock;

   function automatic logic [TOKEN_W-1:0] random_operator();
      case ($urandom_range(0, 3))
         0:       return TOK_PLUS;
         1:       return TOK_MINUS;
         2:       return TOK_STAR;
         default: return TOK_SLASH;
      endcase
   endfunction

   // Mostly decimal digits; now and then any other code that pushes.
   function automatic logic [TOKEN_W-1:0] random_operand();
      logic [TOKEN_W-1:0] tok;
      if ($urandom_range(0, 4) != 0) return ZERO_CODE + TOKEN_W'($urandom_range(0, 9));
      do begin
         tok = TOKEN_W'($urandom_range(0, 255));
      end while (tok == TOK_PLUS || tok == TOK_MINUS || tok == TOK_STAR ||
                 tok == TOK_SLASH || tok == TOK_CARET);
      return tok;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic push_char(input logic [TOKEN_W-1:0] tok, input logic fin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.token <= tok;
      req_ch.last  <= fin;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      chars_sent++;
   endtask

   task automatic send_expression();
      for (int i = 0; i < expr_q.size(); i++) push_char(expr_q[i], i == expr_q.size() - 1);
   endtask

   // Result side: a random stall before each result, none in steady stretches.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n_ops;
      int pushes_left;
      int ops_left;
      int depth;
      int pick;
      int expr_count;
      clock        = 1'b0;
      reset        = 1'b1;
      steady       = 1'b0;
      chars_sent   = 0;
      idle_cycles  = 0;
      expr_count   = 0;
      req_ch.valid = 1'b0;
      req_ch.token = '0;
      req_ch.last  = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Extreme codes with add, multiply and divide: 9 * (-48 + 207) / 3.
      expr_q = '{ZERO_CODE + 8'd9, 8'h00, 8'hFF, TOK_PLUS, TOK_STAR, ZERO_CODE + 8'd3,
                 TOK_SLASH};
      send_expression();
      // Build 128^4 * 8, the most negative value, and divide it by minus one.
      expr_q = '{8'hB0, 8'hB0, TOK_STAR, 8'hB0, TOK_STAR, 8'hB0, TOK_STAR,
                 ZERO_CODE + 8'd8, TOK_STAR, ZERO_CODE, ZERO_CODE + 8'd1, TOK_MINUS,
                 TOK_SLASH};
      send_expression();
      // Division by zero.
      expr_q = '{ZERO_CODE + 8'd6, ZERO_CODE, TOK_SLASH};
      send_expression();
      // Underflow first; the later digit must not clear it.
      expr_q = '{TOK_PLUS, ZERO_CODE + 8'd4};
      send_expression();
      // Unsupported caret.
      expr_q = '{TOK_CARET};
      send_expression();

      while (chars_sent < CHAR_TARGET) begin
         steady = ($urandom_range(0, 5) == 0);
         pick   = $urandom_range(0, 99);
         expr_q.delete();
         if (pick < 8) begin
            // Deep stack: fills to near the limit and sometimes one or two past it.
            repeat ($urandom_range(DEPTH - 2, DEPTH + 2)) expr_q.push_back(random_operand());
            repeat ($urandom_range(0, 4)) expr_q.push_back(random_operator());
         end else if (pick < 90) begin
            n_ops       = $urandom_range(0, 6);
            pushes_left = n_ops + 1;
            ops_left    = n_ops;
            depth       = 0;
            while (pushes_left + ops_left > 0) begin
               if (pushes_left > 0 && (depth < 2 || $urandom_range(0, 1) == 0)) begin
                  expr_q.push_back(random_operand());
                  pushes_left--;
                  depth++;
               end else begin
                  expr_q.push_back(random_operator());
                  ops_left--;
                  depth--;
               end
            end
            // A share of the well-formed ones get one character replaced.
            if (pick >= 80) begin
               expr_q[$urandom_range(0, expr_q.size() - 1)] =
                  ($urandom_range(0, 3) == 0) ? TOK_CARET : random_operator();
            end
         end else begin
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(0, 1) == 0) expr_q.push_back(TOKEN_W'($urandom_range(0, 255)));
               else expr_q.push_back(($urandom_range(0, 4) == 0) ? TOK_CARET : random_operator());
            end
         end
         send_expression();
         expr_count++;
         // Now and then hold the sender until every result has come back.
         if (expr_count % 16 == 0) begin
            req_ch.valid <= 1'b0;
            do @(negedge clock); while (results_outstanding != 0);
         end
      end

      req_ch.valid <= 1'b0;
      while (results_outstanding != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && results_outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/pee_pkg.sv
design/pee_channels.sv
design/pee_alu.sv
design/postfix_expression_evaluator_unit.sv
design/pee_checker.sv
tb/sv/postfix_expression_evaluator_unit_checker.sv
tb/sv/postfix_expression_evaluator_unit_tb.sv
